>>> sv/fcc_pkg.sv
`default_nettype none
package fcc_pkg;

   localparam int MaxFrameBytesDefault = 128;
   localparam int CsrDataWidth = 48;
   localparam int CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_STATION_ADDRESS = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_EXPECTED_TYPE   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_PAYLOAD_LENGTH  = 2'd2;

   localparam logic [47:0] StationAddressReset = 48'h0;
   localparam logic [15:0] ExpectedTypeReset   = 16'h0810;
   localparam logic [6:0]  PayloadLengthReset  = 7'd10;

   localparam logic [31:0] CrcInit = 32'hffff_ffff;
   localparam int FrameOverhead = 18;

   typedef logic [31:0] crc_type;

   localparam crc_type NibbleTable [16] = '{
      32'h00000000, 32'h1db71064, 32'h3b6e20c8, 32'h26d930ac,
      32'h76dc4190, 32'h6b6b51f4, 32'h4db26158, 32'h5005713c,
      32'hedb88320, 32'hf00f9344, 32'hd6d6a3e8, 32'hcb61b38c,
      32'h9b64c2b0, 32'h86d3d2d4, 32'ha00ae278, 32'hbdbdf21c
   };

endpackage
`default_nettype wire

>>> sv/fcc_crc_byte.sv
`default_nettype none
module fcc_crc_byte (
   input  var fcc_pkg::crc_type crc_cur,
   input  var logic [7:0]       data,
   output var fcc_pkg::crc_type crc_next
);
   import fcc_pkg::*;

   crc_type mid;

   // reflected CRC-32, low nibble first
   always_comb begin
      mid      = NibbleTable[crc_cur[3:0] ^ data[3:0]] ^ {4'h0, crc_cur[31:4]};
      crc_next = NibbleTable[mid[3:0] ^ data[7:4]] ^ {4'h0, mid[31:4]};
   end

endmodule
`default_nettype wire

>>> sv/frame_check_crc32_top.sv
`default_nettype none
// A result is loaded into the output register when its last byte leaves the input register.
// Throughput: one byte per cycle; the input register stalls only while a
// last byte waits behind an untaken result in the output register.
// Reset (synchronous, active high) restores the register defaults, clears the
// frame state (CRC to all ones, count and delay line to zero) and empties both stages.
module frame_check_crc32_top #(
   parameter int MAX_FRAME_BYTES = fcc_pkg::MaxFrameBytesDefault
) (
   input  var logic                              clock,
   input  var logic                              reset,
   input  var logic                              req_valid,
   output var logic                              req_ready,
   input  var logic [7:0]                        req_data_byte,
   input  var logic                              req_last_byte,
   output var logic                              rsp_valid,
   input  var logic                              rsp_ready,
   output var logic                              rsp_address_match,
   output var logic                              rsp_type_match,
   output var logic                              rsp_crc_match,
   output var logic                              rsp_length_match,
   output var logic [31:0]                       rsp_computed_crc,
   output var logic [31:0]                       rsp_received_crc,
   input  var logic                              csr_we,
   input  var logic [fcc_pkg::CsrIndexWidth-1:0] csr_index,
   input  var logic [fcc_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import fcc_pkg::*;

   localparam int CountWidth = $clog2(MAX_FRAME_BYTES + 1);
   localparam int CmpWidth   = (CountWidth >= 8) ? CountWidth + 1 : 9;
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(MAX_FRAME_BYTES);

   // configuration registers
   logic [47:0] station_address_ff;
   logic [15:0] expected_type_ff;
   logic [6:0]  payload_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_address_ff <= StationAddressReset;
         expected_type_ff   <= ExpectedTypeReset;
         payload_length_ff  <= PayloadLengthReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STATION_ADDRESS: station_address_ff <= csr_wdata[47:0];
            CSR_EXPECTED_TYPE:   expected_type_ff   <= csr_wdata[15:0];
            CSR_PAYLOAD_LENGTH:  payload_length_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_data_ff;
   logic       s1_last_ff;
   logic       s1_advance;
   logic       req_fire;

   assign s1_advance = s1_valid_ff & (~s1_last_ff | ~rsp_valid | rsp_ready);
   assign req_ready  = ~s1_valid_ff | s1_advance;
   assign req_fire   = req_valid & req_ready;
   assign s1_valid_in = req_fire | (s1_valid_ff & ~s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   // frame state
   crc_type               crc_ff, crc_in, crc_step;
   logic [7:0]            tail_ff [4];
   logic [7:0]            tail_in [4];
   logic [CountWidth-1:0] count_ff, count_in, count_next;
   logic                  address_ok_ff, address_ok_in, address_ok_next;
   logic                  type_ok_ff, type_ok_in, type_ok_next;
   logic [7:0]            want_byte;
   crc_type               crc_next;

   fcc_crc_byte u_crc (
      .crc_cur  (crc_ff),
      .data     (tail_ff[0]),
      .crc_next (crc_step)
   );

   always_comb begin
      case (count_ff[2:0])
         3'd0:    want_byte = station_address_ff[47:40];
         3'd1:    want_byte = station_address_ff[39:32];
         3'd2:    want_byte = station_address_ff[31:24];
         3'd3:    want_byte = station_address_ff[23:16];
         3'd4:    want_byte = station_address_ff[15:8];
         default: want_byte = station_address_ff[7:0];
      endcase
   end

   always_comb begin
      address_ok_next = address_ok_ff;
      type_ok_next    = type_ok_ff;
      if (count_ff < CountWidth'(6)) begin
         address_ok_next = address_ok_ff & (want_byte == s1_data_ff);
      end else if (count_ff == CountWidth'(12)) begin
         type_ok_next = type_ok_ff & (expected_type_ff[15:8] == s1_data_ff);
      end else if (count_ff == CountWidth'(13)) begin
         type_ok_next = type_ok_ff & (expected_type_ff[7:0] == s1_data_ff);
      end
      crc_next   = (count_ff >= CountWidth'(4)) ? crc_step : crc_ff;
      count_next = (count_ff == CountMax) ? CountMax : count_ff + CountWidth'(1);
   end

   always_comb begin
      crc_in        = crc_ff;
      count_in      = count_ff;
      address_ok_in = address_ok_ff;
      type_ok_in    = type_ok_ff;
      tail_in       = tail_ff;
      if (s1_advance) begin
         if (s1_last_ff) begin
            crc_in        = CrcInit;
            count_in      = '0;
            address_ok_in = 1'b1;
            type_ok_in    = 1'b1;
            tail_in       = '{default: 8'h00};
         end else begin
            crc_in        = crc_next;
            count_in      = count_next;
            address_ok_in = address_ok_next;
            type_ok_in    = type_ok_next;
            tail_in       = '{tail_ff[1], tail_ff[2], tail_ff[3], s1_data_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff        <= CrcInit;
         count_ff      <= '0;
         address_ok_ff <= 1'b1;
         type_ok_ff    <= 1'b1;
         tail_ff       <= '{default: 8'h00};
      end else begin
         crc_ff        <= crc_in;
         count_ff      <= count_in;
         address_ok_ff <= address_ok_in;
         type_ok_ff    <= type_ok_in;
         tail_ff       <= tail_in;
      end
   end

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_load;
   logic                address_match_ff, type_match_ff, crc_match_ff, length_match_ff;
   logic [31:0]         computed_crc_ff, received_crc_ff;
   logic [31:0]         rx_word, calc_word;
   logic [CmpWidth-1:0] expected_len;

   assign out_load     = s1_advance & s1_last_ff;
   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_ready);
   assign rx_word      = {tail_ff[1], tail_ff[2], tail_ff[3], s1_data_ff};
   assign calc_word    = ~crc_next;
   assign expected_len = CmpWidth'(payload_length_ff) + CmpWidth'(FrameOverhead);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         address_match_ff <= address_ok_next & (count_next >= CountWidth'(6));
         type_match_ff    <= type_ok_next & (count_next >= CountWidth'(14));
         crc_match_ff     <= (calc_word == rx_word);
         length_match_ff  <= (count_next < CountMax) &
                             (CmpWidth'(count_next) == expected_len);
         computed_crc_ff  <= calc_word;
         received_crc_ff  <= rx_word;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_address_match = address_match_ff;
   assign rsp_type_match    = type_match_ff;
   assign rsp_crc_match     = crc_match_ff;
   assign rsp_length_match  = length_match_ff;
   assign rsp_computed_crc  = computed_crc_ff;
   assign rsp_received_crc  = received_crc_ff;

   a_crc_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_crc_match == (rsp_computed_crc == rsp_received_crc)))
      else $error("crc_match disagrees with the CRC words");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountMax)
      else $error("byte count beyond saturation");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (count_ff == '0) && (crc_ff == CrcInit) && address_ok_ff && type_ok_ff)
      else $error("frame state not cleared after last item");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("empty input stage not ready");

endmodule
`default_nettype wire

>>> tb/frame_check_crc32_checker.sv
`default_nettype none
module frame_check_crc32_checker #(
   parameter int MAX_FRAME_BYTES = fcc_pkg::MaxFrameBytesDefault
) (
   input  var logic                              clock,
   input  var logic                              reset,
   input  var logic                              req_valid,
   input  var logic                              req_ready,
   input  var logic [7:0]                        req_data_byte,
   input  var logic                              req_last_byte,
   input  var logic                              rsp_valid,
   input  var logic                              rsp_ready,
   input  var logic                              rsp_address_match,
   input  var logic                              rsp_type_match,
   input  var logic                              rsp_crc_match,
   input  var logic                              rsp_length_match,
   input  var logic [31:0]                       rsp_computed_crc,
   input  var logic [31:0]                       rsp_received_crc,
   input  var logic                              csr_we,
   input  var logic [fcc_pkg::CsrIndexWidth-1:0] csr_index,
   input  var logic [fcc_pkg::CsrDataWidth-1:0]  csr_wdata,
   output int unsigned                           verdicts_due,
   output int unsigned                           mismatch_count
);

   localparam logic [31:0] CrcPoly = 32'hedb8_8320;

   typedef struct packed {
      logic        address_match;
      logic        type_match;
      logic        crc_match;
      logic        length_match;
      logic [31:0] computed_crc;
      logic [31:0] received_crc;
   } frame_verdict_type;

   logic [47:0]       station;
   logic [15:0]       ether_type;
   logic [6:0]        payload_len;

   logic [31:0]       crc_acc;
   logic [7:0]        tail [4];
   int unsigned       byte_cnt;
   logic              addr_ok;
   logic              type_ok;

   frame_verdict_type verdict_q [$];
   int unsigned       errors = 0;

   // bitwise reflected CRC-32, one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h0, b};
      for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      return r;
   endfunction

   task automatic clear_frame();
      crc_acc = fcc_pkg::CrcInit;
      for (int i = 0; i < 4; i++) tail[i] = 8'h00;
      byte_cnt = 0;
      addr_ok = 1'b1;
      type_ok = 1'b1;
   endtask

   task automatic flag_result(input string why, input frame_verdict_type want,
                              input frame_verdict_type got);
      errors++;
      if (errors <= 10)
         $display("%0s: expected addr %0b type %0b crc %0b len %0b calc %08h rx %08h",
                  why, want.address_match, want.type_match, want.crc_match,
                  want.length_match, want.computed_crc, want.received_crc,
                  "\n   got      addr %0b type %0b crc %0b len %0b calc %08h rx %08h",
                  got.address_match, got.type_match, got.crc_match,
                  got.length_match, got.computed_crc, got.received_crc);
   endtask

   task automatic absorb_byte(input logic [7:0] b, input logic last);
      int unsigned       pos;
      int unsigned       cnt;
      logic [31:0]       rx;
      logic [31:0]       calc;
      frame_verdict_type v;
      pos = byte_cnt;
      if (pos < 6) begin
         if (station[47 - 8*pos -: 8] != b) addr_ok = 1'b0;
      end else if (pos == 12) begin
         if (ether_type[15:8] != b) type_ok = 1'b0;
      end else if (pos == 13) begin
         if (ether_type[7:0] != b) type_ok = 1'b0;
      end
      // oldest held byte cannot be part of the trailing CRC once four are held
      if (pos >= 4) crc_acc = crc32_byte(crc_acc, tail[0]);
      tail[0] = tail[1];
      tail[1] = tail[2];
      tail[2] = tail[3];
      tail[3] = b;
      cnt = pos + 1;
      if (cnt > MAX_FRAME_BYTES) cnt = MAX_FRAME_BYTES;
      byte_cnt = cnt;
      if (last) begin
         rx = {tail[0], tail[1], tail[2], tail[3]};
         calc = ~crc_acc;
         v.address_match = addr_ok && (cnt >= 6);
         v.type_match = type_ok && (cnt >= 14);
         v.crc_match = (calc == rx);
         v.length_match = (cnt < MAX_FRAME_BYTES) &&
                          (cnt == int'(payload_len) + fcc_pkg::FrameOverhead);
         v.computed_crc = calc;
         v.received_crc = rx;
         verdict_q.push_back(v);
         clear_frame();
      end
   endtask

   always @(posedge clock) begin : watch
      frame_verdict_type got;
      frame_verdict_type want;
      if (reset) begin
         station = fcc_pkg::StationAddressReset;
         ether_type = fcc_pkg::ExpectedTypeReset;
         payload_len = fcc_pkg::PayloadLengthReset;
         clear_frame();
         verdict_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               fcc_pkg::CSR_STATION_ADDRESS: station = csr_wdata[47:0];
               fcc_pkg::CSR_EXPECTED_TYPE:   ether_type = csr_wdata[15:0];
               fcc_pkg::CSR_PAYLOAD_LENGTH:  payload_len = csr_wdata[6:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got.address_match = rsp_address_match;
            got.type_match = rsp_type_match;
            got.crc_match = rsp_crc_match;
            got.length_match = rsp_length_match;
            got.computed_crc = rsp_computed_crc;
            got.received_crc = rsp_received_crc;
            if (verdict_q.size() == 0) begin
               flag_result("unexpected result", '0, got);
            end else begin
               want = verdict_q.pop_front();
               if (got.address_match !== want.address_match ||
                   got.type_match !== want.type_match ||
                   got.crc_match !== want.crc_match ||
                   got.length_match !== want.length_match ||
                   got.computed_crc !== want.computed_crc ||
                   got.received_crc !== want.received_crc)
                  flag_result("result mismatch", want, got);
            end
         end
         if (req_valid && req_ready) absorb_byte(req_data_byte, req_last_byte);
      end
      verdicts_due <= verdict_q.size();
      mismatch_count <= errors;
   end

endmodule
`default_nettype wire

>>> tb/tb_frame_check_crc32_top.sv
`default_nettype none
module tb_frame_check_crc32_top;

   localparam int StallLimit = 5000;
   localparam int HoldCycles = 400;
   localparam int BytesPerSetting = 128;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [7:0]                        req_data_byte;
   logic                              req_last_byte;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic                              rsp_address_match;
   logic                              rsp_type_match;
   logic                              rsp_crc_match;
   logic                              rsp_length_match;
   logic [31:0]                       rsp_computed_crc;
   logic [31:0]                       rsp_received_crc;
   logic                              csr_we;
   logic [fcc_pkg::CsrIndexWidth-1:0] csr_index;
   logic [fcc_pkg::CsrDataWidth-1:0]  csr_wdata;

   int unsigned verdicts_due;
   int unsigned mismatch_count;

   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   logic        tx_busy = 1'b0;
   logic        hold_req = 1'b0;
   logic        hold_ack = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   logic [47:0] cur_station;
   logic [15:0] cur_type;
   logic [6:0]  cur_plen;
   logic [7:0]  frame_buf [256];

   frame_check_crc32_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_address_match (rsp_address_match),
      .rsp_type_match    (rsp_type_match),
      .rsp_crc_match     (rsp_crc_match),
      .rsp_length_match  (rsp_length_match),
      .rsp_computed_crc  (rsp_computed_crc),
      .rsp_received_crc  (rsp_received_crc),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   frame_check_crc32_checker u_chk (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_address_match (rsp_address_match),
      .rsp_type_match    (rsp_type_match),
      .rsp_crc_match     (rsp_crc_match),
      .rsp_length_match  (rsp_length_match),
      .rsp_computed_crc  (rsp_computed_crc),
      .rsp_received_crc  (rsp_received_crc),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .verdicts_due      (verdicts_due),
      .mismatch_count    (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= HoldCycles;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("tb_frame_check_crc32_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [31:0] fcs_of(input int len);
      logic [31:0] c;
      c = 32'hffff_ffff;
      for (int i = 0; i < len; i++) begin
         c = c ^ {24'h0, frame_buf[i]};
         for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hedb8_8320) : (c >> 1);
      end
      return ~c;
   endfunction

   // mostly well-formed frames with random content, some damaged, long or noise
   function automatic int make_frame();
      int          kind;
      int          n;
      int          want;
      logic [31:0] fcs;
      want = int'(cur_plen) + fcc_pkg::FrameOverhead;
      kind = $urandom_range(99);
      n = want;
      if (kind >= 70 && kind < 85) n = $urandom_range(want + 3, 1);
      else if (kind >= 85 && kind < 92) n = $urandom_range(140, 129);
      else if (kind >= 92) n = $urandom_range(20, 1);
      for (int i = 0; i < n; i++) frame_buf[i] = 8'($urandom_range(255));
      if (kind < 92) begin
         for (int i = 0; i < 6; i++) frame_buf[i] = cur_station[47 - 8*i -: 8];
         frame_buf[12] = cur_type[15:8];
         frame_buf[13] = cur_type[7:0];
         if ($urandom_range(4) == 0)
            frame_buf[$urandom_range(5)] ^= 8'h01 << $urandom_range(7);
         if ($urandom_range(4) == 0)
            frame_buf[12 + $urandom_range(1)] ^= 8'h01 << $urandom_range(7);
         if (n >= 4) begin
            fcs = fcs_of(n - 4);
            frame_buf[n-4] = fcs[31:24];
            frame_buf[n-3] = fcs[23:16];
            frame_buf[n-2] = fcs[15:8];
            frame_buf[n-1] = fcs[7:0];
         end
         if ($urandom_range(4) == 0)
            frame_buf[$urandom_range(n - 1)] ^= 8'h01 << $urandom_range(7);
      end
      return n;
   endfunction

   task automatic drop_valid();
      if (tx_busy) begin
         req_valid <= 1'b0;
         tx_busy = 1'b0;
      end
   endtask

   task automatic send_byte(input logic [7:0] d, input logic last);
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= last;
      tx_busy = 1'b1;
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(99) < tx_idle_pct) begin
         drop_valid();
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
   endtask

   task automatic send_frame(input int n);
      for (int i = 0; i < n; i++) send_byte(frame_buf[i], i == n - 1);
   endtask

   // wait for every result, then the pipeline latency
   task automatic settle();
      drop_valid();
      do @(posedge clock); while (verdicts_due != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [fcc_pkg::CsrIndexWidth-1:0] idx,
                            input logic [47:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   task automatic program_settings(input int idx);
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      cur_station = r[47:0];
      cur_type = r[63:48];
      cur_plen = 7'($urandom_range(8));
      case (idx)
         0: begin
            cur_station = '0;
            cur_type = '0;
            cur_plen = '0;
         end
         1: begin
            cur_station = '1;
            cur_type = '1;
            cur_plen = '1;
         end
         3: cur_plen = 7'd110;
         4: cur_plen = 7'd109;
         default: ;
      endcase
      write_csr(fcc_pkg::CSR_STATION_ADDRESS, cur_station);
      write_csr(fcc_pkg::CSR_EXPECTED_TYPE, {32'h0, cur_type});
      write_csr(fcc_pkg::CSR_PAYLOAD_LENGTH, {41'h0, cur_plen});
      csr_we <= 1'b0;
   endtask

   initial begin
      int sent;
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_last_byte = 1'b0;
      csr_we = 1'b0;
      csr_index = fcc_pkg::CSR_STATION_ADDRESS;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // short frames under reset settings: 1, 3 and 4 bytes, then 6 and 14
      send_byte(8'hff, 1'b1);
      for (int i = 0; i < 3; i++) send_byte(8'h00, i == 2);
      for (int i = 0; i < 4; i++) send_byte(8'hff, i == 3);
      for (int i = 0; i < 6; i++) send_byte(8'h00, i == 5);
      for (int i = 0; i < 12; i++) send_byte(i < 6 ? 8'h00 : 8'hff, 1'b0);
      send_byte(8'h08, 1'b0);
      send_byte(8'h10, 1'b1);

      for (int ph = 0; ph < 3; ph++) begin
         tx_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 83 : 0;
         rx_idle_pct <= (ph == 0) ? 83 : (ph == 1) ? 12 : 0;
         for (int s = 0; s < 3; s++) begin
            settle();
            program_settings(ph * 3 + s);
            if (s == 2) hold_req <= ~hold_req;
            sent = 0;
            while (sent < BytesPerSetting) begin
               n = make_frame();
               send_frame(n);
               sent += n;
            end
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_frame_check_crc32_top: PASS");
      end else begin
         $display("tb_frame_check_crc32_top: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
